@@ rtl/akt_pkg.sv @@
package akt_pkg;

  localparam int unsigned TableDepthDef = 256;

  localparam logic [14:0] Q_ONE       = 15'd16384;
  localparam logic [15:0] EXT_PREFIX  = 16'hE000;
  localparam logic [13:0] DEADZONE_RST = 14'd328;
  localparam logic        ENABLED_RST = 1'b0;

  // restoring divide: one integer bit and fourteen fraction bits
  localparam int unsigned DivSteps = 15;
  localparam logic [3:0]  DIV_LAST = 4'(DivSteps - 1);

  localparam logic REG_ENABLED  = 1'b0;
  localparam logic REG_DEADZONE = 1'b1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_LOAD  = 2'd1,
    OP_END   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] code;
    logic [15:0] value;
    logic        key_nz;
  } cmd_t;

  typedef struct packed {
    logic        enabled;
    logic [13:0] deadzone;
  } cfg_t;

endpackage

@@ rtl/akt_ram.sv @@
module akt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/akt_front.sv @@
module akt_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   action_i,
  input  logic [15:0]  entry_code_i,
  input  logic [15:0]  entry_value_i,
  input  logic [7:0]   query_key_i,
  output akt_pkg::cmd_t cmd_o,
  output logic         cmd_valid_o,
  input  logic         cmd_pop_i
);
  import akt_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;
  logic [15:0] mapped;

  // scan code to key code: extended keys carry the E0 prefix
  always_comb begin
    if (query_key_i[7]) begin
      mapped = EXT_PREFIX | {9'd0, query_key_i[6:0]};
    end else begin
      mapped = {8'd0, query_key_i};
    end
  end

  always_comb begin
    cmd_in.op     = op_e'(action_i);
    cmd_in.value  = entry_value_i;
    cmd_in.key_nz = (query_key_i != 8'd0);
    if (op_e'(action_i) == OP_QUERY) begin
      cmd_in.code = mapped;
    end else begin
      cmd_in.code = entry_code_i;
    end
  end

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

endmodule

@@ rtl/akt_back.sv @@
module akt_back #(
  parameter int unsigned TABLE_DEPTH = akt_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  akt_pkg::cfg_t cfg_i,
  input  akt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output logic          done_o,
  output logic          pressed_o,
  output logic [14:0]   level_o
);
  import akt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          valid_q, valid_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [15:0]   code_q, code_d;
  logic [15:0]   best_q, best_d;
  logic [15:0]   rem_q, rem_d;
  logic [14:0]   quo_q, quo_d;
  logic [14:0]   dvs_q, dvs_d;
  logic [3:0]    step_q, step_d;
  logic          done_q, done_d;
  logic          pressed_q, pressed_d;
  logic [14:0]   level_q, level_d;

  logic          ram_we, ram_re;
  logic [31:0]   ram_rdata;
  logic [15:0]   best_upd;
  logic [14:0]   best_clamp;
  logic [15:0]   rem_sh;
  logic          rem_ge;
  logic [15:0]   rem_sub;
  logic          last_idx;

  akt_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({cmd_i.code, cmd_i.value}),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // running maximum over entries whose code matches
  always_comb begin
    best_upd = best_q;
    if (pend_q && (ram_rdata[31:16] == code_q) && (ram_rdata[15:0] > best_q)) begin
      best_upd = ram_rdata[15:0];
    end
  end

  assign best_clamp = (best_q > {1'b0, Q_ONE}) ? Q_ONE : best_q[14:0];
  assign last_idx   = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    rem_sh  = (step_q == 4'd0) ? rem_q : {rem_q[14:0], 1'b0};
    rem_ge  = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    code_d    = code_q;
    best_d    = best_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    step_d    = step_q;
    done_d    = 1'b0;
    pressed_d = pressed_q;
    level_d   = level_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    cmd_pop_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_BEGIN: begin
              count_d = '0;
              valid_d = 1'b0;
            end
            OP_LOAD: begin
              if (count_q < CW'(TABLE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_END: begin
              valid_d = cfg_i.enabled;
            end
            OP_QUERY: begin
              if (!valid_q || !cmd_i.key_nz || (count_q == '0)) begin
                done_d    = 1'b1;
                pressed_d = 1'b0;
                level_d   = '0;
              end else begin
                code_d  = cmd_i.code;
                best_d  = '0;
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read data arrives in the cycle after the address
        ram_re = 1'b1;
        pend_d = 1'b1;
        best_d = best_upd;
        if (last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        best_d  = best_upd;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (best_q == 16'd0) begin
          done_d    = 1'b1;
          pressed_d = 1'b0;
          level_d   = '0;
          state_d   = ST_IDLE;
        end else if (best_clamp <= {1'b0, cfg_i.deadzone}) begin
          done_d    = 1'b1;
          pressed_d = 1'b1;
          level_d   = '0;
          state_d   = ST_IDLE;
        end else begin
          rem_d   = {1'b0, best_clamp - {1'b0, cfg_i.deadzone}};
          dvs_d   = Q_ONE - {1'b0, cfg_i.deadzone};
          quo_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = rem_ge ? rem_sub : rem_sh;
        quo_d  = {quo_q[13:0], rem_ge};
        step_d = step_q + 4'd1;
        if (step_q == DIV_LAST) begin
          done_d    = 1'b1;
          pressed_d = 1'b1;
          level_d   = {quo_q[13:0], rem_ge};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    code_q    <= code_d;
    best_q    <= best_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    dvs_q     <= dvs_d;
    step_q    <= step_d;
    pressed_q <= pressed_d;
    level_q   <= level_d;
  end

  assign done_o    = done_q;
  assign pressed_o = pressed_q;
  assign level_o   = level_q;

`ifndef SYNTH
  a_scan_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (valid_q && (count_q != '0)))
    else $error("query scan running without a valid sample");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CW'(TABLE_DEPTH)))
    else $error("table write past capacity");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (level_q <= Q_ONE))
    else $error("level above full travel");

  a_level_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !pressed_q) |-> (level_q == '0))
    else $error("nonzero level on an unpressed result");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_pop_o)
    else $error("item taken from queue while a query runs");
`endif

endmodule

@@ rtl/analog_key_table_deadzone_lookup.sv @@
// Analog key snapshot table with deadzone lookup.
// Items enter on start while busy is low; action selects begin sample, load
// entry, end sample or query key. Items go into a two-entry queue and are
// carried out in order by the back end, so busy rises only when that queue
// is full.
// Begin, load and end are carried out by the back end and give no result.
// A query gives one result: done_o is high for exactly one cycle with
// pressed_o and level_o. The receiver cannot stall; each result must be
// taken in the cycle it is shown.
// A query with an invalid sample, a zero key or an empty table is answered
// from the idle state; otherwise the table is scanned through the single
// read port of the entry memory, and then the bit-serial divider runs when
// the travel is above the deadzone. No new item is taken while a query
// runs, so the table scan and the divider set the rate of queries.
// Configuration: APB port, enabled at 0x0 and deadzone at 0x4; write only
// while no item is outstanding.
// Reset empties the table and the queue, marks the sample invalid, clears
// enabled and sets deadzone to 328. No clearing pass is needed.
module analog_key_table_deadzone_lookup #(
  parameter int unsigned TABLE_DEPTH = akt_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] entry_code_i,
  input  logic [15:0] entry_value_i,
  input  logic [7:0]  query_key_i,
  output logic        done_o,
  output logic        pressed_o,
  output logic [14:0] level_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import akt_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (paddr[2])
        REG_ENABLED:  cfg_d.enabled  = pwdata[0];
        REG_DEADZONE: cfg_d.deadzone = pwdata[13:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled  <= ENABLED_RST;
      cfg_q.deadzone <= DEADZONE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = (paddr[2] == REG_DEADZONE) ? {18'd0, cfg_q.deadzone}
                                             : {31'd0, cfg_q.enabled};

  akt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .entry_code_i (entry_code_i),
    .entry_value_i(entry_value_i),
    .query_key_i  (query_key_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  akt_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .done_o     (done_o),
    .pressed_o  (pressed_o),
    .level_o    (level_o)
  );

endmodule

@@ dv/tb_analog_key_table_deadzone_lookup.sv @@
module tb_analog_key_table_deadzone_lookup;
  import akt_pkg::*;

  localparam int unsigned DEPTH         = TableDepthDef;
  localparam int unsigned FULL_TRAVEL   = 16384;
  localparam logic [15:0] EXT_CODE      = 16'hE000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS  = 250;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned GAP_PERCENT   = 26;

  typedef struct packed {
    logic        pressed;
    logic [14:0] level;
  } key_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [1:0]  action_i      = '0;
  logic [15:0] entry_code_i  = '0;
  logic [15:0] entry_value_i = '0;
  logic [7:0]  query_key_i   = '0;
  logic        done_o;
  logic        pressed_o;
  logic [14:0] level_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the snapshot table and registers
  logic [15:0] snap_code  [DEPTH];
  logic [15:0] snap_value [DEPTH];
  int unsigned snap_count   = 0;
  bit          snap_valid   = 1'b0;
  bit          cfg_enabled  = ENABLED_RST;
  logic [13:0] cfg_deadzone = DEADZONE_RST;

  key_result_t pending_results[$];

  bit          gaps_on          = 1'b1;
  int unsigned cycle_count      = 0;
  int unsigned mismatches       = 0;
  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned pressed_expected = 0;
  int unsigned loads_dropped    = 0;
  int unsigned reg_writes       = 0;

  analog_key_table_deadzone_lookup u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .entry_code_i  (entry_code_i),
    .entry_value_i (entry_value_i),
    .query_key_i   (query_key_i),
    .done_o        (done_o),
    .pressed_o     (pressed_o),
    .level_o       (level_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [15:0] scan_to_code(logic [7:0] key);
    return key[7] ? (EXT_CODE | {9'd0, key[6:0]}) : {8'd0, key};
  endfunction

  // updates the shadow table; a query pushes the expected pressed/level pair
  function automatic void track_snapshot(op_e op, logic [15:0] code, logic [15:0] value,
                                         logic [7:0] key);
    key_result_t want;
    logic [15:0] target;
    int unsigned best;
    want = '0;
    best = 0;
    case (op)
      OP_BEGIN: begin
        snap_count = 0;
        snap_valid = 1'b0;
      end
      OP_LOAD: begin
        if (snap_count < DEPTH) begin
          snap_code[snap_count]  = code;
          snap_value[snap_count] = value;
          snap_count++;
        end else begin
          loads_dropped++;
        end
      end
      OP_END: snap_valid = cfg_enabled;
      default: begin
        if (snap_valid && key != 8'd0) begin
          target = scan_to_code(key);
          for (int unsigned i = 0; i < snap_count; i++) begin
            if (snap_code[i] == target && snap_value[i] > best) best = snap_value[i];
          end
          if (best != 0) begin
            if (best > FULL_TRAVEL) best = FULL_TRAVEL;
            want.pressed = 1'b1;
            if (best > cfg_deadzone) begin
              want.level = 15'(((best - cfg_deadzone) * FULL_TRAVEL) /
                               (FULL_TRAVEL - cfg_deadzone));
            end
            pressed_expected++;
          end
        end
        pending_results.push_back(want);
      end
    endcase
  endfunction

  task automatic send_item(op_e op, logic [15:0] code, logic [15:0] value, logic [7:0] key);
    if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < GAP_PERCENT);
    end
    start         <= 1'b1;
    action_i      <= op;
    entry_code_i  <= code;
    entry_value_i <= value;
    query_key_i   <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    track_snapshot(op, code, value, key);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    start <= 1'b0;
    wait_drained();
    // loads and ends give no result, so let the back end finish them
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ENABLED) cfg_enabled = data[0];
    else cfg_deadzone = data[13:0];
    reg_writes++;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("lookup result with none pending, level", 32'(level_o), 0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (pressed_o !== want.pressed) begin
          report_mismatch("pressed", 32'(pressed_o), 32'(want.pressed));
        end
        if (level_o !== want.level) begin
          report_mismatch("level", 32'(level_o), 32'(want.level));
        end
      end
    end
  end

  // enabled is still at reset, so the sample never turns valid
  task automatic test_disabled_sample();
    send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_LOAD, 16'h001E, 16'd8000, 8'($urandom));
    send_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h1E);
  endtask

  task automatic test_lookup_cases();
    write_reg(REG_ENABLED, 32'd1);
    send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_LOAD, 16'h001E, 16'hFFFF, 8'($urandom));
    send_item(OP_LOAD, 16'h001E, 16'd100, 8'($urandom));
    send_item(OP_LOAD, 16'hE048, 16'd16384, 8'($urandom));
    send_item(OP_LOAD, 16'h0030, 16'd200, 8'($urandom));
    send_item(OP_LOAD, 16'h0031, 16'd0, 8'($urandom));
    send_item(OP_LOAD, 16'h0032, 16'd329, 8'($urandom));
    send_item(OP_LOAD, 16'hE07F, 16'd1, 8'($urandom));
    send_item(OP_LOAD, 16'h0030, 16'd328, 8'($urandom));
    send_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h1E);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'hC8);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h30);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h31);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h00);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h32);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'hFF);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h55);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h80);
    // a load after the end still counts
    send_item(OP_LOAD, 16'h0055, 16'd9000, 8'($urandom));
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h55);
    send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h1E);
  endtask

  task automatic test_deadzone_extremes();
    send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_LOAD, 16'h0040, 16'd16383, 8'($urandom));
    send_item(OP_LOAD, 16'h0041, 16'd16384, 8'($urandom));
    send_item(OP_LOAD, 16'h0042, 16'd1, 8'($urandom));
    send_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
    write_reg(REG_DEADZONE, 32'd0);
    for (int k = 8'h40; k <= 8'h42; k++) send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'(k));
    write_reg(REG_DEADZONE, 32'd16383);
    for (int k = 8'h40; k <= 8'h42; k++) send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'(k));
    write_reg(REG_DEADZONE, 32'(DEADZONE_RST));
  endtask

  // fills every entry, then two loads that must be dropped; no idling here
  task automatic test_table_full();
    logic [7:0] key;
    gaps_on = 1'b0;
    send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
    for (int unsigned i = 0; i < DEPTH; i++) begin
      key = {1'(i % 2), 7'(i % 127 + 1)};
      send_item(OP_LOAD, scan_to_code(key), 16'($urandom_range(15000)), 8'($urandom));
    end
    repeat (2) send_item(OP_LOAD, scan_to_code(8'h7F), 16'(FULL_TRAVEL), 8'($urandom));
    send_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h7F);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'hFF);
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'h01);
    repeat (3) send_item(OP_QUERY, 16'($urandom), 16'($urandom), 8'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_samples();
    int unsigned first_item;
    int unsigned sample_no;
    int unsigned n_loads;
    logic [7:0]  pool [4];
    logic [7:0]  key;
    logic [15:0] code;
    logic [15:0] travel;
    first_item = items_sent;
    sample_no  = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      sample_no++;
      if (sample_no % 6 == 0) begin
        case ($urandom_range(3))
          0:       write_reg(REG_DEADZONE, 32'd0);
          1:       write_reg(REG_DEADZONE, 32'd16383);
          2:       write_reg(REG_DEADZONE, 32'(DEADZONE_RST));
          default: write_reg(REG_DEADZONE, 32'($urandom_range(16383)));
        endcase
        write_reg(REG_ENABLED, 32'($urandom_range(4) != 0));
      end
      if (sample_no == 9) begin
        start <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(9) == 0) begin
        // noise: any action, any fields
        repeat ($urandom_range(5, 15)) begin
          send_item(op_e'($urandom_range(3)), 16'($urandom), 16'($urandom), 8'($urandom));
        end
      end else begin
        foreach (pool[i]) pool[i] = 8'($urandom_range(1, 255));
        n_loads = ($urandom_range(24) == 0) ? $urandom_range(200, 260) : $urandom_range(12);
        send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom));
        repeat (n_loads) begin
          code = ($urandom_range(3) != 0) ? scan_to_code(pool[$urandom_range(3)])
                                          : 16'($urandom);
          case ($urandom_range(5))
            0:       travel = '0;
            1:       travel = 16'($urandom_range(1, 400));
            2:       travel = 16'(int'(cfg_deadzone) + int'($urandom_range(2)) - 1);
            3:       travel = 16'(FULL_TRAVEL);
            4:       travel = 16'($urandom_range(16385, 65535));
            default: travel = 16'($urandom);
          endcase
          send_item(OP_LOAD, code, travel, 8'($urandom));
        end
        if ($urandom_range(9) != 0) begin
          send_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(1, 6)) begin
          key = ($urandom_range(4) != 0) ? pool[$urandom_range(3)] : 8'($urandom);
          send_item(OP_QUERY, 16'($urandom), 16'($urandom), key);
        end
        if ($urandom_range(5) == 0) begin
          send_item(OP_LOAD, scan_to_code(pool[0]), 16'($urandom_range(FULL_TRAVEL)),
                    8'($urandom));
          send_item(OP_QUERY, 16'($urandom), 16'($urandom), pool[0]);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_sample();
    test_lookup_cases();
    test_deadzone_extremes();
    test_table_full();
    test_random_samples();

    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d lookups checked, %0d of them pressed, %0d loads dropped",
             items_sent, results_checked, pressed_expected, loads_dropped);
    $display("%0d register writes across enable and deadzone settings, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/akt_pkg.sv
rtl/akt_ram.sv
rtl/akt_front.sv
rtl/akt_back.sv
rtl/analog_key_table_deadzone_lookup.sv
dv/tb_analog_key_table_deadzone_lookup.sv
